### src/pur_pkg.sv
// ----------------------------------------------------------------------------
// pur_pkg
// Shared types and constants for the partial update region unit: item
// layouts, configuration record, queue entry and status codes.
// ----------------------------------------------------------------------------
package pur_pkg;

    localparam int COORD_BITS  = 13;
    localparam int PORCH_BITS  = COORD_BITS + 1;
    localparam int FP_BITS     = 10;
    localparam int STATUS_BITS = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PARTIAL_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_COLS       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRONT_PORCH      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COMPRESS_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLICE_ROWS       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COMPRESSED_WIDTH = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUAL_LINK        = 3'd7;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_APPLIED    = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_DISABLED   = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_UNCHANGED  = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD_XW     = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_SLICE = 3'd4;
    localparam logic [STATUS_BITS-1:0] STATUS_MISALIGNED = 3'd5;
    localparam logic [STATUS_BITS-1:0] STATUS_RESET_DONE = 3'd6;

    // Input command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    // Kind of work queued for the back end
    localparam logic [1:0] KIND_UPDATE   = 2'd0;
    localparam logic [1:0] KIND_RESET    = 2'd1;
    localparam logic [1:0] KIND_DISABLED = 2'd2;

    typedef struct packed {
        logic                  command;
        logic [COORD_BITS-1:0] rect_x;
        logic [COORD_BITS-1:0] rect_y;
        logic [COORD_BITS-1:0] rect_w;
        logic [COORD_BITS-1:0] rect_h;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [COORD_BITS-1:0]  link_width;
        logic [COORD_BITS-1:0]  link_height;
        logic [PORCH_BITS-1:0]  link_porch;
        logic [COORD_BITS-1:0]  region_x;
        logic [COORD_BITS-1:0]  region_y;
        logic [COORD_BITS-1:0]  region_w;
        logic [COORD_BITS-1:0]  region_h;
    } out_item_t;

    typedef struct packed {
        logic                  partial_enable;
        logic [COORD_BITS-1:0] panel_cols;
        logic [COORD_BITS-1:0] panel_height;
        logic [FP_BITS-1:0]    front_porch;
        logic                  compress_enable;
        logic [COORD_BITS-1:0] slice_rows;
        logic [COORD_BITS-1:0] compressed_width;
        logic                  dual_link;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  bad_xw;
        logic                  zero_slice;
        logic [COORD_BITS-1:0] rect_x;
        logic [COORD_BITS-1:0] rect_y;
        logic [COORD_BITS-1:0] rect_w;
        logic [COORD_BITS-1:0] rect_h;
    } q_entry_t;

endpackage

### src/pur_front.sv
// ----------------------------------------------------------------------------
// pur_front
// Classifies an incoming request: command kind, empty-to-full-screen mapping
// and the geometry checks that depend only on the request and configuration.
// ----------------------------------------------------------------------------
module pur_front (
    input  pur_pkg::cfg_t     cfg,
    input  pur_pkg::in_item_t item,
    output pur_pkg::q_entry_t entry
);

    logic is_empty;

    // Detect the all-zero rectangle
    assign is_empty = (item.rect_x == '0) && (item.rect_y == '0)
                   && (item.rect_w == '0) && (item.rect_h == '0);

    // Build the queue entry
    always_comb
    begin
        entry            = '0;
        entry.rect_x     = item.rect_x;
        entry.rect_y     = item.rect_y;
        entry.rect_w     = is_empty ? cfg.panel_cols   : item.rect_w;
        entry.rect_h     = is_empty ? cfg.panel_height : item.rect_h;
        entry.bad_xw     = cfg.compress_enable
                        && ((item.rect_x != '0) || (entry.rect_w != cfg.panel_cols));
        entry.zero_slice = cfg.compress_enable && (cfg.slice_rows == '0);
        if (item.command == pur_pkg::CMD_RESET)
        begin
            // reset carries the full-screen rectangle to be stored
            entry.kind   = pur_pkg::KIND_RESET;
            entry.rect_x = '0;
            entry.rect_y = '0;
            entry.rect_w = cfg.panel_cols;
            entry.rect_h = cfg.panel_height;
        end
        else if (!cfg.partial_enable)
        begin
            entry.kind = pur_pkg::KIND_DISABLED;
        end
        else
        begin
            entry.kind = pur_pkg::KIND_UPDATE;
        end
    end

endmodule

### src/pur_fifo.sv
// ----------------------------------------------------------------------------
// pur_fifo
// Short queue of classified requests between the front and back ends.
// Read data is registered and holds until the next pop.
// ----------------------------------------------------------------------------
module pur_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pur_pkg::q_entry_t push_data,
    input  logic              pop,
    output pur_pkg::q_entry_t pop_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pur_pkg::q_entry_t mem [DEPTH];
    pur_pkg::q_entry_t pop_data_reg;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = pop_data_reg;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write and registered read
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            pop_data_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

### src/pur_back.sv
// ----------------------------------------------------------------------------
// pur_back
// Carries out queued requests: compare with the stored rectangle, slice
// alignment by bit-serial remainder, update of the stored rectangle and the
// registered result item.
// ----------------------------------------------------------------------------
module pur_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pur_pkg::cfg_t     cfg,
    input  logic              q_empty,
    input  pur_pkg::q_entry_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output pur_pkg::out_item_t out_item
);

    localparam int CW    = pur_pkg::COORD_BITS;
    localparam int PW    = pur_pkg::PORCH_BITS;
    localparam int CNT_W = $clog2(CW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    bit_idx;
    logic [CW-1:0]       rem_y_reg, rem_y_next;
    logic [CW-1:0]       rem_h_reg, rem_h_next;
    logic [CW:0]         rem_y_sh, rem_h_sh, slice_ext;
    logic [CW-1:0]       stored_x_reg, stored_x_next;
    logic [CW-1:0]       stored_y_reg, stored_y_next;
    logic [CW-1:0]       stored_w_reg, stored_w_next;
    logic [CW-1:0]       stored_h_reg, stored_h_next;
    logic                out_valid_reg, out_valid_next;
    pur_pkg::out_item_t  out_item_reg, out_item_next;
    pur_pkg::out_item_t  applied_item;
    logic                out_free;
    logic                unchanged;
    logic                emit;
    logic                store;
    logic [CW-1:0]       lw_full;
    logic [PW-1:0]       porch_sum;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Compare with the stored rectangle
    assign unchanged = (q_data.rect_x == stored_x_reg) && (q_data.rect_y == stored_y_reg)
                    && (q_data.rect_w == stored_w_reg) && (q_data.rect_h == stored_h_reg);

    // Form the result of an applied update
    always_comb
    begin
        lw_full   = cfg.compress_enable ? cfg.compressed_width : q_data.rect_w;
        porch_sum = PW'(cfg.front_porch) + PW'(cfg.panel_height);
        applied_item             = '0;
        applied_item.status      = pur_pkg::STATUS_APPLIED;
        applied_item.link_width  = cfg.dual_link ? (lw_full >> 1) : lw_full;
        applied_item.link_height = q_data.rect_h;
        applied_item.link_porch  = (porch_sum > PW'(q_data.rect_h))
                                 ? porch_sum - PW'(q_data.rect_h) : '0;
        applied_item.region_x    = cfg.dual_link ? (q_data.rect_x >> 1) : q_data.rect_x;
        applied_item.region_y    = q_data.rect_y;
        applied_item.region_w    = cfg.dual_link ? (q_data.rect_w >> 1) : q_data.rect_w;
        applied_item.region_h    = q_data.rect_h;
    end

    // One remainder bit per cycle for y and height
    assign bit_idx   = CNT_W'(CW - 1) - cnt_reg;
    assign slice_ext = {1'b0, cfg.slice_rows};
    assign rem_y_sh  = {rem_y_reg, q_data.rect_y[bit_idx]};
    assign rem_h_sh  = {rem_h_reg, q_data.rect_h[bit_idx]};

    // Sequence one request at a time
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rem_y_next    = rem_y_reg;
        rem_h_next    = rem_h_reg;
        out_item_next = out_item_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        store         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_item_next = '0;
                    state_next    = S_IDLE;
                    if (q_data.kind == pur_pkg::KIND_RESET)
                    begin
                        out_item_next.status = pur_pkg::STATUS_RESET_DONE;
                        store                = 1'b1;
                    end
                    else if (q_data.kind == pur_pkg::KIND_DISABLED)
                    begin
                        out_item_next.status = pur_pkg::STATUS_DISABLED;
                    end
                    else if (unchanged)
                    begin
                        out_item_next.status = pur_pkg::STATUS_UNCHANGED;
                    end
                    else if (q_data.bad_xw)
                    begin
                        out_item_next.status = pur_pkg::STATUS_BAD_XW;
                    end
                    else if (q_data.zero_slice)
                    begin
                        out_item_next.status = pur_pkg::STATUS_ZERO_SLICE;
                    end
                    else if (cfg.compress_enable)
                    begin
                        // hold the result until alignment is known
                        emit          = 1'b0;
                        out_item_next = out_item_reg;
                        cnt_next      = '0;
                        rem_y_next    = '0;
                        rem_h_next    = '0;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        out_item_next = applied_item;
                        store         = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                rem_y_next = (rem_y_sh >= slice_ext) ? CW'(rem_y_sh - slice_ext)
                                                     : rem_y_sh[CW-1:0];
                rem_h_next = (rem_h_sh >= slice_ext) ? CW'(rem_h_sh - slice_ext)
                                                     : rem_h_sh[CW-1:0];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CW - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if ((rem_y_reg != '0) || (rem_h_reg != '0))
                    begin
                        out_item_next        = '0;
                        out_item_next.status = pur_pkg::STATUS_MISALIGNED;
                    end
                    else
                    begin
                        out_item_next = applied_item;
                        store         = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Update stored rectangle and output valid
    always_comb
    begin
        stored_x_next  = store ? q_data.rect_x : stored_x_reg;
        stored_y_next  = store ? q_data.rect_y : stored_y_reg;
        stored_w_next  = store ? q_data.rect_w : stored_w_reg;
        stored_h_next  = store ? q_data.rect_h : stored_h_reg;
        out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            stored_x_reg  <= '0;
            stored_y_reg  <= '0;
            stored_w_reg  <= '0;
            stored_h_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            stored_x_reg  <= stored_x_next;
            stored_y_reg  <= stored_y_next;
            stored_w_reg  <= stored_w_next;
            stored_h_reg  <= stored_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_y_reg    <= rem_y_next;
        rem_h_reg    <= rem_h_next;
        out_item_reg <= out_item_next;
    end

endmodule

### src/dsi_partial_update_region_unit.sv
// ----------------------------------------------------------------------------
// dsi_partial_update_region_unit
// Dirty-rectangle request handling for a display serial link: validates a
// requested region, keeps the current one and reports link timing and panel
// region values.
// ----------------------------------------------------------------------------
// Requests enter a queue of QUEUE_DEPTH items and are carried out one at a
// time, each giving exactly one result item. A request that needs no slice
// alignment check has its result in the output register once the back end
// has read the queue head and evaluated it. An update that reaches the
// alignment check with compression on goes through the read and evaluate
// steps, the bit-serial remainder unit that produces one bit of y and height
// modulo the slice height per cycle, and a report step. A stalled output
// holds the evaluate or report step until the output register is free. Input
// is taken while the queue has room, and a finished result waits in the
// output register without blocking the queue. Configuration is written
// through the cfg port, which is always ready, and should be changed only
// while no request is in flight.
// ----------------------------------------------------------------------------
module dsi_partial_update_region_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  pur_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output pur_pkg::out_item_t                    out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pur_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [pur_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int CW = pur_pkg::COORD_BITS;

    pur_pkg::cfg_t     cfg_reg, cfg_next;
    pur_pkg::q_entry_t push_entry;
    pur_pkg::q_entry_t head_entry;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              push;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pur_pkg::REG_PARTIAL_ENABLE:   cfg_next.partial_enable   = cfg_data[0];
                pur_pkg::REG_PANEL_COLS:       cfg_next.panel_cols       = cfg_data[CW-1:0];
                pur_pkg::REG_PANEL_HEIGHT:     cfg_next.panel_height     = cfg_data[CW-1:0];
                pur_pkg::REG_FRONT_PORCH:
                    cfg_next.front_porch = cfg_data[pur_pkg::FP_BITS-1:0];
                pur_pkg::REG_COMPRESS_ENABLE:  cfg_next.compress_enable  = cfg_data[0];
                pur_pkg::REG_SLICE_ROWS:       cfg_next.slice_rows       = cfg_data[CW-1:0];
                pur_pkg::REG_COMPRESSED_WIDTH: cfg_next.compressed_width = cfg_data[CW-1:0];
                pur_pkg::REG_DUAL_LINK:        cfg_next.dual_link        = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pur_front u_front (
        .cfg   (cfg_reg),
        .item  (in_item),
        .entry (push_entry)
    );

    pur_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (q_pop),
        .pop_data  (head_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    pur_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (head_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
